// ===== src/segmented_lru_demote_cache_top_defines.svh =====
// Assertion macros for the segmented LRU cache.
`ifndef SEGMENTED_LRU_DEMOTE_CACHE_TOP_DEFINES_SVH
`define SEGMENTED_LRU_DEMOTE_CACHE_TOP_DEFINES_SVH
`ifndef SYNTH
`define SLRU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SLRU_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLRU_ASSERT(label, clk, rst_n, prop, msg)
`define SLRU_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== src/slru_pkg.sv =====
package slru_pkg;
    localparam int PROT_ENTRIES = 32;
    localparam int PROB_ENTRIES = 32;
    localparam int NENT = PROT_ENTRIES + PROB_ENTRIES;
    localparam int IW = $clog2(NENT);
    localparam int CW = $clog2(NENT + 1);

    localparam logic SEG_PROT = 1'b0;
    localparam logic SEG_PROB = 1'b1;

    localparam logic [1:0] CFG_PROT_CAP = 2'd0;
    localparam logic [1:0] CFG_PROB_CAP = 2'd1;
    localparam logic [1:0] CFG_BLOCK_SIZE = 2'd2;

    localparam logic [2:0] OUT_PROT_DEMOTE_HIT = 3'd0;
    localparam logic [2:0] OUT_PROT_READ_HIT = 3'd1;
    localparam logic [2:0] OUT_PROB_DEMOTE_HIT = 3'd2;
    localparam logic [2:0] OUT_PROB_READ_HIT = 3'd3;
    localparam logic [2:0] OUT_DEMOTE_MISS = 3'd4;
    localparam logic [2:0] OUT_READ_MISS = 3'd5;

    // Search request and answer between the sequencer and the tag scanner.
    typedef struct packed {
        logic          start;
        logic          find_free;
        logic [31:0]   obj;
        logic [31:0]   blk;
    } scan_req_t;

    typedef struct packed {
        logic          done;
        logic          found;
        logic [IW-1:0] index;
    } scan_rsp_t;
endpackage

// ===== src/slru_scan.sv =====
// Sequential tag scanner: walks the tag store one entry a cycle, looking
// either for a matching valid entry or for the first free one.
module slru_scan
    import slru_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  scan_req_t       req,
    input  logic [NENT-1:0] valid,
    input  logic            wr_en,
    input  logic [IW-1:0]   wr_index,
    input  logic [31:0]     wr_obj,
    input  logic [31:0]     wr_blk,
    output scan_rsp_t       rsp
);
    logic [31:0] tag_object [NENT];
    logic [31:0] tag_block [NENT];
    logic [31:0] rd_obj_reg;
    logic [31:0] rd_blk_reg;
    logic        rd_valid_reg;
    logic        active_reg;
    logic        pend_reg;
    logic [IW-1:0] addr_reg;
    logic [IW-1:0] cmp_index_reg;
    logic        last_reg;
    logic        match;

    // Tag memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_object[wr_index] <= wr_obj;
            tag_block[wr_index] <= wr_blk;
        end
        rd_obj_reg <= tag_object[addr_reg];
        rd_blk_reg <= tag_block[addr_reg];
    end

    assign match = req.find_free ? !rd_valid_reg
                 : (rd_valid_reg && rd_obj_reg == req.obj && rd_blk_reg == req.blk);

    // Address walker; the comparison happens in the cycle after its address is issued.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pend_reg <= 1'b0;
            addr_reg <= '0;
            cmp_index_reg <= '0;
            last_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
            rsp <= '0;
        end
        else
        begin
            rsp.done <= 1'b0;
            rd_valid_reg <= valid[addr_reg];
            if (req.start)
            begin
                active_reg <= 1'b1;
                pend_reg <= 1'b0;
                addr_reg <= '0;
            end
            else if (active_reg)
            begin
                pend_reg <= 1'b1;
                cmp_index_reg <= addr_reg;
                last_reg <= (addr_reg == IW'(NENT - 1));
                if (addr_reg != IW'(NENT - 1))
                    addr_reg <= addr_reg + 1'b1;
                if (pend_reg && (match || last_reg))
                begin
                    active_reg <= 1'b0;
                    pend_reg <= 1'b0;
                    rsp.done <= 1'b1;
                    rsp.found <= match;
                    rsp.index <= cmp_index_reg;
                end
            end
        end
    end

    `include "segmented_lru_demote_cache_top_defines.svh"
    `SLRU_ASSERT(a_done_one_cycle, clk, rst_n, rsp.done |=> !rsp.done, "scan done held")
    `SLRU_ASSERT(a_start_idle, clk, rst_n, req.start |=> !rsp.done, "done right after start")
    `SLRU_ASSERT(a_wr_not_scanning, clk, rst_n, wr_en |-> !active_reg, "tag write during scan")
endmodule

// ===== src/slru_mul.sv =====
// Shift-and-add multiplier for the forwarded address, one bit a cycle.
module slru_mul
    import slru_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] multiplicand,
    input  logic [16:0] multiplier,
    output logic [47:0] product,
    output logic        done
);
    logic [47:0] acc_reg;
    logic [47:0] mcand_reg;
    logic [16:0] mplier_reg;
    logic [4:0]  count_reg;
    logic        busy_reg;

    assign product = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            count_reg <= '0;
            acc_reg <= '0;
            mcand_reg <= '0;
            mplier_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                acc_reg <= '0;
                mcand_reg <= {16'd0, multiplicand};
                mplier_reg <= multiplier;
                count_reg <= 5'd0;
            end
            else if (busy_reg)
            begin
                if (mplier_reg[0])
                    acc_reg <= acc_reg + mcand_reg;
                mcand_reg <= {mcand_reg[46:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[16:1]};
                count_reg <= count_reg + 1'b1;
                if (count_reg == 5'd16)
                begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== src/segmented_lru_demote_cache_top.sv =====
// Segmented LRU block cache (protected and probationary segments).
// Command channel: an item is taken when start is high and busy is low;
// command 0 is a read, 1 a demote, naming object_id and block_id.
// busy rises in the cycle after acceptance and stays high until the result.
// The result is shown on the result ports for one cycle with done high;
// the receiver cannot stall, so it must sample it in that cycle.
// Sequence: the tag search walks the 64-entry store one entry a cycle,
// a miss then walks again for a free entry, and a read miss runs a
// 17-step shift-and-add multiply; list pointer updates take states of
// their own. A new item may be accepted in the result cycle.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready
// is high only while the cache is idle, so no write lands mid-item.
// Reset clears all valid bits, segment heads, tails and counts at once and
// restores capacities 32 and 32 and block size 4096; no clearing pass.
module segmented_lru_demote_cache_top
    import slru_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [31:0] object_id,
    input  logic [31:0] block_id,
    output logic        done,
    output logic [2:0]  outcome,
    output logic        moved_down,
    output logic        moved_up,
    output logic        dropped,
    output logic        forward_read,
    output logic [47:0] forward_address,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_HIT_UNLINK, S_PROT_FREE, S_PROB_FREE,
        S_DOWN, S_DROP, S_FREE, S_FREE_WAIT, S_APPEND, S_MUL, S_DONE
    } state_t;

    state_t state_reg;
    logic [5:0]  prot_cap_reg, prob_cap_reg;
    logic [16:0] block_size_reg;

    logic [NENT-1:0] valid_reg;
    logic [NENT-1:0] seg_reg;
    logic [IW-1:0] nxt_reg [NENT];
    logic [IW-1:0] prv_reg [NENT];
    logic [IW-1:0] head_reg [2];
    logic [IW-1:0] tail_reg [2];
    logic [CW-1:0] count_reg [2];

    logic        cmd_reg;
    logic [31:0] obj_reg, blk_reg;
    logic [IW-1:0] hit_reg;
    logic [IW-1:0] tgt_reg;
    logic        tgt_seg_reg;
    logic        miss_reg;
    logic        down_pending_reg;

    logic [IW-1:0] rd_addr;
    logic [IW-1:0] rd_nxt_reg;
    logic [IW-1:0] rd_prv_reg;
    logic          rd_seg_reg;

    scan_req_t scan_req;
    scan_rsp_t scan_rsp;
    logic      tag_wr;
    logic      mul_start, mul_done;
    logic [47:0] mul_product;

    logic [CW-1:0] prot_cap, prob_cap;
    logic prot_full, prob_full;

    assign cfg_ready = (state_reg == S_IDLE);
    assign busy = (state_reg != S_IDLE);

    // Effective capacities, clamped to 1..segment size.
    always_comb
    begin
        prot_cap = CW'(prot_cap_reg);
        if (prot_cap_reg == 6'd0) prot_cap = CW'(1);
        else if (prot_cap_reg > 6'(PROT_ENTRIES)) prot_cap = CW'(PROT_ENTRIES);
        prob_cap = CW'(prob_cap_reg);
        if (prob_cap_reg == 6'd0) prob_cap = CW'(1);
        else if (prob_cap_reg > 6'(PROB_ENTRIES)) prob_cap = CW'(PROB_ENTRIES);
    end
    assign prot_full = count_reg[SEG_PROT] >= prot_cap;
    assign prob_full = count_reg[SEG_PROB] >= prob_cap;

    assign scan_req.start = (state_reg == S_IDLE && start) || (state_reg == S_FREE);
    assign scan_req.find_free = (state_reg == S_FREE) || (state_reg == S_FREE_WAIT);
    assign scan_req.obj = (state_reg == S_IDLE) ? object_id : obj_reg;
    assign scan_req.blk = (state_reg == S_IDLE) ? block_id : blk_reg;
    assign tag_wr = (state_reg == S_APPEND) && miss_reg;
    assign mul_start = (state_reg == S_APPEND) && miss_reg && !cmd_reg;

    slru_scan u_scan (
        .clk(clk), .rst_n(rst_n), .req(scan_req), .valid(valid_reg),
        .wr_en(tag_wr), .wr_index(tgt_reg), .wr_obj(obj_reg), .wr_blk(blk_reg),
        .rsp(scan_rsp)
    );

    slru_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .multiplicand(blk_reg),
        .multiplier(block_size_reg), .product(mul_product), .done(mul_done)
    );

    // The entry that the next state unlinks; its pointers and segment are
    // fetched in the state before, through a registered read port.
    always_comb
    begin
        unique case (state_reg)
            S_SEARCH:     rd_addr = scan_rsp.found ? scan_rsp.index : head_reg[SEG_PROT];
            S_HIT_UNLINK: rd_addr = head_reg[SEG_PROT];
            S_PROB_FREE:  rd_addr = head_reg[SEG_PROB];
            default:      rd_addr = head_reg[SEG_PROT];
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_nxt_reg <= nxt_reg[rd_addr];
        rd_prv_reg <= prv_reg[rd_addr];
        rd_seg_reg <= seg_reg[rd_addr];
    end

    // Head, tail and count side of an unlink.
    task automatic unlink(input logic [IW-1:0] u);
        logic s;
        s = rd_seg_reg;
        if (u == head_reg[s]) head_reg[s] <= rd_nxt_reg;
        if (u == tail_reg[s]) tail_reg[s] <= rd_prv_reg;
        if (count_reg[s] != '0) count_reg[s] <= count_reg[s] - 1'b1;
    endtask

    // Head, tail, count and valid side of an append.
    task automatic append(input logic [IW-1:0] u, input logic s);
        if (count_reg[s] == '0) head_reg[s] <= u;
        tail_reg[s] <= u;
        count_reg[s] <= count_reg[s] + 1'b1;
        valid_reg[u] <= 1'b1;
    endtask

    // Sequencer and list state. Each list step (unlink or append) takes one
    // state, so the pointer logic touches only a few entries per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            prot_cap_reg <= 6'd32;
            prob_cap_reg <= 6'd32;
            block_size_reg <= 17'd4096;
            valid_reg <= '0;
            head_reg[0] <= '0; head_reg[1] <= '0;
            tail_reg[0] <= '0; tail_reg[1] <= '0;
            count_reg[0] <= '0; count_reg[1] <= '0;
            done <= 1'b0;
            outcome <= '0; moved_down <= 1'b0; moved_up <= 1'b0;
            dropped <= 1'b0; forward_read <= 1'b0; forward_address <= '0;
            cmd_reg <= 1'b0; obj_reg <= '0; blk_reg <= '0;
            hit_reg <= '0; tgt_reg <= '0; tgt_seg_reg <= 1'b0; miss_reg <= 1'b0;
            down_pending_reg <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_PROT_CAP:   prot_cap_reg <= cfg_data[5:0];
                    CFG_PROB_CAP:   prob_cap_reg <= cfg_data[5:0];
                    CFG_BLOCK_SIZE: block_size_reg <= cfg_data[16:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg <= command; obj_reg <= object_id; blk_reg <= block_id;
                        moved_down <= 1'b0; moved_up <= 1'b0; dropped <= 1'b0;
                        forward_read <= 1'b0; forward_address <= '0;
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    if (scan_rsp.done)
                    begin
                        hit_reg <= scan_rsp.index;
                        miss_reg <= !scan_rsp.found;
                        if (scan_rsp.found)
                            state_reg <= S_HIT_UNLINK;
                        else if (cmd_reg)
                        begin
                            outcome <= OUT_DEMOTE_MISS;
                            tgt_seg_reg <= SEG_PROT;
                            state_reg <= S_PROT_FREE;
                        end
                        else
                        begin
                            outcome <= OUT_READ_MISS;
                            tgt_seg_reg <= SEG_PROB;
                            state_reg <= S_PROB_FREE;
                        end
                    end
                end
                S_HIT_UNLINK:
                begin
                    unlink(hit_reg);
                    tgt_reg <= hit_reg;
                    if (rd_seg_reg == SEG_PROT)
                    begin
                        if (cmd_reg)
                        begin
                            outcome <= OUT_PROT_DEMOTE_HIT;
                            tgt_seg_reg <= SEG_PROT;
                            state_reg <= S_APPEND;
                        end
                        else
                        begin
                            outcome <= OUT_PROT_READ_HIT;
                            tgt_seg_reg <= SEG_PROB;
                            state_reg <= S_PROB_FREE;
                        end
                    end
                    else
                    begin
                        outcome <= cmd_reg ? OUT_PROB_DEMOTE_HIT : OUT_PROB_READ_HIT;
                        moved_up <= 1'b1;
                        tgt_seg_reg <= SEG_PROT;
                        state_reg <= S_PROT_FREE;
                    end
                end
                S_PROT_FREE:
                begin
                    // Counts here already reflect the unlink of a hit.
                    if (prot_full)
                    begin
                        moved_down <= 1'b1;
                        unlink(head_reg[SEG_PROT]);
                        hit_reg <= head_reg[SEG_PROT];
                        down_pending_reg <= 1'b1;
                        state_reg <= (miss_reg) ? S_PROB_FREE : S_DOWN;
                    end
                    else
                        state_reg <= miss_reg ? S_FREE : S_APPEND;
                end
                S_PROB_FREE:
                begin
                    if (prob_full && count_reg[SEG_PROB] != '0)
                    begin
                        dropped <= 1'b1;
                        state_reg <= S_DROP;
                    end
                    else
                    begin
                        dropped <= dropped | prob_full;
                        state_reg <= down_pending_reg ? S_DOWN
                                   : (miss_reg ? S_FREE : S_APPEND);
                    end
                end
                S_DROP:
                begin
                    unlink(head_reg[SEG_PROB]);
                    valid_reg[head_reg[SEG_PROB]] <= 1'b0;
                    state_reg <= down_pending_reg ? S_DOWN
                               : (miss_reg ? S_FREE : S_APPEND);
                end
                S_DOWN:
                begin
                    append(hit_reg, SEG_PROB);
                    down_pending_reg <= 1'b0;
                    state_reg <= miss_reg ? S_FREE : S_APPEND;
                end
                S_FREE:
                    state_reg <= S_FREE_WAIT;
                S_FREE_WAIT:
                begin
                    if (scan_rsp.done)
                    begin
                        tgt_reg <= scan_rsp.index;
                        state_reg <= scan_rsp.found ? S_APPEND : S_DONE;
                    end
                end
                S_APPEND:
                begin
                    append(tgt_reg, tgt_seg_reg);
                    state_reg <= (miss_reg && !cmd_reg) ? S_MUL : S_DONE;
                end
                S_MUL:
                begin
                    if (mul_done)
                    begin
                        forward_read <= 1'b1;
                        forward_address <= mul_product;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (miss_reg && !cmd_reg)
                        forward_read <= 1'b1;
                    done <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Pointer array writes are kept out of the reset block (payload).
    logic          pw_en_n, pw_en_p, pw2_en_n, pw2_en_p;
    logic [IW-1:0] pw_a_n, pw_d_n, pw_a_p, pw_d_p, pw2_a_n, pw2_d_n, pw2_a_p, pw2_d_p;
    logic          sw_en, sw_d;
    logic [IW-1:0] sw_a;

    // Pointer updates of the current list step.
    always_comb
    begin
        logic [IW-1:0] u, t;
        logic s;
        pw_en_n = 1'b0; pw_en_p = 1'b0; pw2_en_n = 1'b0; pw2_en_p = 1'b0;
        pw_a_n = '0; pw_d_n = '0; pw_a_p = '0; pw_d_p = '0;
        pw2_a_n = '0; pw2_d_n = '0; pw2_a_p = '0; pw2_d_p = '0;
        sw_en = 1'b0; sw_d = 1'b0; sw_a = '0;
        u = '0; t = '0; s = 1'b0;
        priority case (1'b1)
            (state_reg == S_HIT_UNLINK), (state_reg == S_DROP),
            (state_reg == S_PROT_FREE && prot_full):
            begin
                u = (state_reg == S_HIT_UNLINK) ? hit_reg
                  : (state_reg == S_DROP) ? head_reg[SEG_PROB] : head_reg[SEG_PROT];
                s = rd_seg_reg;
                if (u != head_reg[s])
                begin
                    pw_en_n = 1'b1; pw_a_n = rd_prv_reg; pw_d_n = rd_nxt_reg;
                end
                if (u != tail_reg[s])
                begin
                    pw_en_p = 1'b1; pw_a_p = rd_nxt_reg; pw_d_p = rd_prv_reg;
                end
            end
            (state_reg == S_DOWN), (state_reg == S_APPEND):
            begin
                u = (state_reg == S_DOWN) ? hit_reg : tgt_reg;
                s = (state_reg == S_DOWN) ? SEG_PROB : tgt_seg_reg;
                t = tail_reg[s];
                sw_en = 1'b1; sw_a = u; sw_d = s;
                if (count_reg[s] != '0)
                begin
                    pw2_en_n = 1'b1; pw2_a_n = t; pw2_d_n = u;
                    pw2_en_p = 1'b1; pw2_a_p = u; pw2_d_p = t;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pw_en_n) nxt_reg[pw_a_n] <= pw_d_n;
        if (pw2_en_n) nxt_reg[pw2_a_n] <= pw2_d_n;
        if (pw_en_p) prv_reg[pw_a_p] <= pw_d_p;
        if (pw2_en_p) prv_reg[pw2_a_p] <= pw2_d_p;
        if (sw_en) seg_reg[sw_a] <= sw_d;
    end

    `include "segmented_lru_demote_cache_top_defines.svh"
    `SLRU_ASSERT(a_done_pulse, clk, rst_n, done |=> !done, "done longer than a cycle")
    `SLRU_ASSERT(a_fwd_read_miss, clk, rst_n,
        done && forward_read |-> outcome == OUT_READ_MISS, "forward on non read miss")
    `SLRU_ASSERT(a_up_prob_hit, clk, rst_n,
        done && moved_up |-> (outcome == OUT_PROB_DEMOTE_HIT || outcome == OUT_PROB_READ_HIT),
        "promotion without probationary hit")
endmodule
